[rtl/kvqt_pkg.sv]
// Shared types and constants for the key-value query table.
`default_nettype none
package kvqt_pkg;

   localparam int FIELD_BITS     = 64;
   localparam int CAPACITY_DEF   = 64;
   localparam int KEY_BITS_DEF   = 64;
   localparam int VALUE_BITS_DEF = 64;

   localparam logic CMD_READ  = 1'b0;
   localparam logic CMD_WRITE = 1'b1;

   typedef enum logic [1:0] {
      ST_OK   = 2'd0,
      ST_MISS = 2'd1,
      ST_FULL = 2'd2
   } status_type;

   // control part of a query walking down the cell row
   typedef struct packed {
      logic valid;
      logic write;
      logic done;
      logic miss;
   } token_ctrl_type;

endpackage
`default_nettype wire

[rtl/kvqt_if.sv]
// Request and response channel interfaces of the key-value query table.
`default_nettype none
interface kvqt_req_if
   import kvqt_pkg::*;
();
   logic                  valid;
   logic                  ready;
   logic                  cmd;
   logic [FIELD_BITS-1:0] key;
   logic [FIELD_BITS-1:0] value;

   modport source(output valid, output cmd, output key, output value, input ready);
   modport sink(input valid, input cmd, input key, input value, output ready);
endinterface

interface kvqt_rsp_if
   import kvqt_pkg::*;
();
   logic                  valid;
   logic                  ready;
   status_type            status;
   logic [FIELD_BITS-1:0] value_out;

   modport source(output valid, output status, output value_out, input ready);
   modport sink(input valid, input status, input value_out, output ready);
endinterface
`default_nettype wire

[rtl/kvqt_cell.sv]
// One table slot: holds an entry and serves the query passing through it.
`default_nettype none
module kvqt_cell
   import kvqt_pkg::*;
#(
   parameter int KEY_BITS   = KEY_BITS_DEF,
   parameter int VALUE_BITS = VALUE_BITS_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  advance,
   input  wire token_ctrl_type        in_ctrl,
   input  wire logic [KEY_BITS-1:0]   in_key,
   input  wire logic [VALUE_BITS-1:0] in_value,
   output token_ctrl_type             out_ctrl_ff,
   output logic [KEY_BITS-1:0]        out_key_ff,
   output logic [VALUE_BITS-1:0]      out_value_ff
);

   logic                  entry_valid_ff, entry_valid_in;
   logic [KEY_BITS-1:0]   entry_key_ff, entry_key_in;
   logic [VALUE_BITS-1:0] entry_value_ff, entry_value_in;
   token_ctrl_type        out_ctrl_in;
   logic [VALUE_BITS-1:0] out_value_in;
   logic                  active;
   logic                  match;

   assign active = in_ctrl.valid && !in_ctrl.done;
   assign match  = entry_valid_ff && (entry_key_ff == in_key);

   always_comb begin
      entry_valid_in = entry_valid_ff;
      entry_key_in   = entry_key_ff;
      entry_value_in = entry_value_ff;
      out_ctrl_in    = in_ctrl;
      out_value_in   = in_value;
      if (active && match) begin
         out_ctrl_in.done = 1'b1;
         if (in_ctrl.write) begin
            entry_value_in = in_value;
         end else begin
            out_value_in = entry_value_ff;
         end
      end else if (active && !entry_valid_ff) begin
         // slots fill in order: first free slot means the key is absent
         out_ctrl_in.done = 1'b1;
         if (in_ctrl.write) begin
            entry_valid_in = 1'b1;
            entry_key_in   = in_key;
            entry_value_in = in_value;
         end else begin
            out_ctrl_in.miss = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_valid_ff <= 1'b0;
         out_ctrl_ff    <= '0;
      end else if (advance) begin
         entry_valid_ff <= entry_valid_in;
         out_ctrl_ff    <= out_ctrl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         entry_key_ff   <= entry_key_in;
         entry_value_ff <= entry_value_in;
         out_key_ff     <= in_key;
         out_value_ff   <= out_value_in;
      end
   end

endmodule
`default_nettype wire

[rtl/key_value_query_table.sv]
// Top level of the exact-match key-value query table.
//
// Channels: req carries one query item (cmd, key, value); rsp returns one
// item (status, value_out) per query, in query order.
// Cmd read returns the stored value with status ok, or status miss and the
// query's own value. Cmd write overwrites a stored key, inserts a new key
// into the next free slot, or reports full and changes nothing.
// Structure: a row of CAPACITY slot cells followed by the rsp register; each
// query steps one cell per cycle while rsp does not stall.
// Queries overlap in the row, so one item per cycle is accepted while rsp
// does not stall; a later query always sees the effect of an earlier one on
// every slot.
// Reset clears all slots (empty table) and drops items in flight; req.ready
// is low while reset is high.
// When rsp stalls with an item held, the whole row freezes and req.ready
// goes low until that item is taken.
`default_nettype none
module key_value_query_table
   import kvqt_pkg::*;
#(
   parameter int CAPACITY   = CAPACITY_DEF,
   parameter int KEY_BITS   = KEY_BITS_DEF,
   parameter int VALUE_BITS = VALUE_BITS_DEF
) (
   input  wire logic   clock,
   input  wire logic   reset,
   kvqt_req_if.sink    req,
   kvqt_rsp_if.source  rsp
);

   token_ctrl_type        link_ctrl  [CAPACITY+1];
   logic [KEY_BITS-1:0]   link_key   [CAPACITY+1];
   logic [VALUE_BITS-1:0] link_value [CAPACITY+1];

   logic                  advance;
   logic                  rsp_valid_ff;
   status_type            rsp_status_ff, rsp_status_in;
   logic [VALUE_BITS-1:0] rsp_value_ff;
   token_ctrl_type        tail;

   assign advance   = !rsp_valid_ff || rsp.ready;
   assign req.ready = advance && !reset;

   assign link_ctrl[0]  = token_ctrl_type'({req.valid, (req.cmd == CMD_WRITE), 1'b0, 1'b0});
   assign link_key[0]   = req.key[KEY_BITS-1:0];
   assign link_value[0] = req.value[VALUE_BITS-1:0];

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      kvqt_cell #(
         .KEY_BITS   (KEY_BITS),
         .VALUE_BITS (VALUE_BITS)
      ) u_cell (
         .clock        (clock),
         .reset        (reset),
         .advance      (advance),
         .in_ctrl      (link_ctrl[i]),
         .in_key       (link_key[i]),
         .in_value     (link_value[i]),
         .out_ctrl_ff  (link_ctrl[i+1]),
         .out_key_ff   (link_key[i+1]),
         .out_value_ff (link_value[i+1])
      );
   end

   assign tail = link_ctrl[CAPACITY];

   always_comb begin
      if (tail.done) begin
         rsp_status_in = tail.miss ? ST_MISS : ST_OK;
      end else begin
         rsp_status_in = tail.write ? ST_FULL : ST_MISS;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= tail.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_status_ff <= rsp_status_in;
         rsp_value_ff  <= link_value[CAPACITY];
      end
   end

   assign rsp.valid     = rsp_valid_ff;
   assign rsp.status    = rsp_status_ff;
   assign rsp.value_out = FIELD_BITS'(rsp_value_ff);

endmodule
`default_nettype wire
